@@ hw/rtl/kta_pkg.sv @@
// Shared constants and types of the Kahan tile accumulator.
`timescale 1ns / 1ps
package kta_pkg;

  localparam int MAX_WIDTH_DEF  = 256;
  localparam int MAX_HEIGHT_DEF = 256;
  localparam int CFG_W          = 9;
  localparam int DIM_W          = 13;
  localparam int ENTRY_W        = 128;

  localparam logic CFG_IDX_WIDTH  = 1'b0;
  localparam logic CFG_IDX_HEIGHT = 1'b1;

  localparam logic CMD_ACCUM = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  typedef struct packed {
    logic        start;
    logic        sub;
    logic [63:0] a;
    logic [63:0] b;
  } fadd_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] result;
  } fadd_rsp_t;

endpackage

@@ hw/rtl/kahan_tile_accumulator.sv @@
// Top level of the Kahan tile accumulator: sequencer, registers and result stage.
`timescale 1ns / 1ps
// Each item targets pixel origin plus offset in an image of MAX_WIDTH x MAX_HEIGHT doubles.
// After reset a clearing pass zeroes the store; in_tready stays low meanwhile. An
// accumulate runs four dependent additions through the one shared double adder. An
// addition ends early when an operand is NaN or infinite or its result is an exact zero,
// and it takes longer with a long normalising shift.
// The block takes one item at a time; a finished result waits in the output register.
module kahan_tile_accumulator
  import kta_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
)(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // origin_x, origin_y, offset_x, offset_y, pixel_value, zero pad
  input  logic [103:0] in_tdata,
  // command
  input  logic         in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // sum_value
  output logic [63:0]  out_tdata,
  // outside
  output logic         out_tuser,
  input  logic         cfg_we,
  input  logic         cfg_addr,
  input  logic [CFG_W-1:0] cfg_wdata
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_CHK   = 4'd2;
  localparam logic [3:0] S_LOAD  = 4'd3;
  localparam logic [3:0] S_A1    = 4'd4;
  localparam logic [3:0] S_A2    = 4'd5;
  localparam logic [3:0] S_A3    = 4'd6;
  localparam logic [3:0] S_A4    = 4'd7;
  localparam logic [3:0] S_FIN   = 4'd8;

  logic [3:0]       state_r, state_nxt;
  logic [AW-1:0]    clr_r;
  logic [CFG_W-1:0] width_r, height_r;
  logic             cmd_r;
  logic [9:0]       px_r, py_r;
  logic [63:0]      val_r, s_r, y_r, t_r;
  logic [AW-1:0]    addr_r;
  logic             res_out_r;
  logic [63:0]      res_sum_r;
  logic             ov_r;
  logic [63:0]      od_r;
  logic             ou_r;

  logic [DIM_W-1:0]   w_eff, h_eff;
  logic               outside;
  logic [AW-1:0]      addr_calc, mem_addr;
  logic               mem_we;
  logic [ENTRY_W-1:0] mem_wdata, mem_rdata;
  fadd_req_t          req;
  fadd_rsp_t          rsp;

  assign w_eff = (DIM_W'(width_r) < DIM_W'(MAX_WIDTH)) ? DIM_W'(width_r) : DIM_W'(MAX_WIDTH);
  assign h_eff = (DIM_W'(height_r) < DIM_W'(MAX_HEIGHT)) ? DIM_W'(height_r)
                                                          : DIM_W'(MAX_HEIGHT);
  assign outside = px_r[9] || py_r[9] || (DIM_W'(px_r[8:0]) >= w_eff)
                   || (DIM_W'(py_r[8:0]) >= h_eff);
  assign addr_calc = AW'(32'(py_r[8:0]) * 32'(MAX_WIDTH) + 32'(px_r[8:0]));

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    mem_we    = 1'b0;
    mem_addr  = addr_calc;
    mem_wdata = {rsp.result, t_r};
    req.start = 1'b0;
    req.sub   = 1'b1;
    req.a     = val_r;
    req.b     = mem_rdata[127:64];
    unique case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_r;
        mem_wdata = '0;
        if (32'(clr_r) == DEPTH - 1) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_tvalid) state_nxt = S_CHK;
      end
      S_CHK: begin
        state_nxt = outside ? S_FIN : S_LOAD;
      end
      S_LOAD: begin
        if (cmd_r == CMD_READ) begin
          state_nxt = S_FIN;
        end else begin
          req.start = 1'b1;
          state_nxt = S_A1;
        end
      end
      S_A1: begin
        req.a   = s_r;
        req.b   = rsp.result;
        req.sub = 1'b0;
        if (rsp.done) begin
          req.start = 1'b1;
          state_nxt = S_A2;
        end
      end
      S_A2: begin
        req.a = rsp.result;
        req.b = s_r;
        if (rsp.done) begin
          req.start = 1'b1;
          state_nxt = S_A3;
        end
      end
      S_A3: begin
        req.a = rsp.result;
        req.b = y_r;
        if (rsp.done) begin
          req.start = 1'b1;
          state_nxt = S_A4;
        end
      end
      S_A4: begin
        mem_addr = addr_r;
        if (rsp.done) begin
          mem_we    = 1'b1;
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!ov_r || out_tready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLEAR;
      clr_r    <= '0;
      width_r  <= CFG_W'(256);
      height_r <= CFG_W'(256);
      ov_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) clr_r <= clr_r + AW'(1);
      if (cfg_we) begin
        unique case (cfg_addr)
          CFG_IDX_WIDTH:  width_r  <= cfg_wdata;
          CFG_IDX_HEIGHT: height_r <= cfg_wdata;
          default: ;
        endcase
      end
      if ((state_r == S_FIN) && (!ov_r || out_tready)) ov_r <= 1'b1;
      else if (out_tready) ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      cmd_r <= in_tuser;
      px_r  <= {in_tdata[8], in_tdata[8:0]} + {2'b00, in_tdata[25:18]};
      py_r  <= {in_tdata[17], in_tdata[17:9]} + {2'b00, in_tdata[33:26]};
      val_r <= in_tdata[97:34];
    end
    if (state_r == S_CHK) begin
      addr_r    <= addr_calc;
      res_out_r <= outside;
      res_sum_r <= '0;
    end
    if (state_r == S_LOAD) begin
      s_r       <= mem_rdata[63:0];
      res_sum_r <= mem_rdata[63:0];
    end
    if ((state_r == S_A1) && rsp.done) y_r <= rsp.result;
    if ((state_r == S_A2) && rsp.done) t_r <= rsp.result;
    if ((state_r == S_A4) && rsp.done) res_sum_r <= t_r;
    if ((state_r == S_FIN) && (!ov_r || out_tready)) begin
      od_r <= res_sum_r;
      ou_r <= res_out_r;
    end
  end

  kta_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  kta_fp_add u_add (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tuser  = ou_r;

endmodule

@@ hw/rtl/kta_fp_add.sv @@
// Multi-cycle IEEE-754 double adder and subtractor, round to nearest even.
`timescale 1ns / 1ps
module kta_fp_add
  import kta_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  fadd_req_t req,
  output fadd_rsp_t rsp
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_UNPK  = 3'd1;
  localparam logic [2:0] S_ALIGN = 3'd2;
  localparam logic [2:0] S_ADD   = 3'd3;
  localparam logic [2:0] S_NORM  = 3'd4;
  localparam logic [2:0] S_ROUND = 3'd5;

  logic [2:0]  state_r, state_nxt;
  logic [63:0] a_r, b_r;
  logic        sub_r;
  logic        sign_r, sign_nxt;
  logic        esub_r, esub_nxt;
  logic [11:0] e_r, e_nxt;
  logic [11:0] d_r, d_nxt;
  logic [55:0] ma_r, ma_nxt;
  logic [55:0] mb_r, mb_nxt;
  logic [56:0] m_r, m_nxt;
  logic [63:0] res_r, res_nxt;
  logic        done_r, done_nxt;

  logic        sbx, a_nan, b_nan, a_inf, b_inf, a_big;
  logic [63:0] big, little;
  logic [11:0] e_big, e_small;
  logic [55:0] shifted, mask;
  logic [10:0] ef;
  logic [63:0] pack;
  logic        up;

  always_comb begin
    state_nxt = state_r;
    sign_nxt  = sign_r;
    esub_nxt  = esub_r;
    e_nxt     = e_r;
    d_nxt     = d_r;
    ma_nxt    = ma_r;
    mb_nxt    = mb_r;
    m_nxt     = m_r;
    res_nxt   = res_r;
    done_nxt  = 1'b0;
    sbx       = b_r[63] ^ sub_r;
    a_nan     = (a_r[62:52] == 11'h7FF) && (a_r[51:0] != 52'd0);
    b_nan     = (b_r[62:52] == 11'h7FF) && (b_r[51:0] != 52'd0);
    a_inf     = (a_r[62:52] == 11'h7FF) && (a_r[51:0] == 52'd0);
    b_inf     = (b_r[62:52] == 11'h7FF) && (b_r[51:0] == 52'd0);
    a_big     = a_r[62:0] >= b_r[62:0];
    big       = a_big ? a_r : b_r;
    little    = a_big ? b_r : a_r;
    e_big     = (big[62:52] == 11'd0) ? 12'd1 : {1'b0, big[62:52]};
    e_small   = (little[62:52] == 11'd0) ? 12'd1 : {1'b0, little[62:52]};
    shifted   = mb_r >> d_r[5:0];
    mask      = (56'd1 << d_r[5:0]) - 56'd1;
    ef        = m_r[55] ? e_r[10:0] : 11'd0;
    pack      = {sign_r, ef, m_r[54:3]};
    up        = m_r[2] & (m_r[1] | m_r[0] | m_r[3]);
    unique case (state_r)
      S_IDLE: begin
        if (req.start) state_nxt = S_UNPK;
      end
      S_UNPK: begin
        if (a_nan) begin
          res_nxt = a_r | 64'h0008_0000_0000_0000;
          done_nxt = 1'b1;
          state_nxt = S_IDLE;
        end else if (b_nan) begin
          res_nxt = b_r | 64'h0008_0000_0000_0000;
          done_nxt = 1'b1;
          state_nxt = S_IDLE;
        end else if (a_inf) begin
          res_nxt = (b_inf && (a_r[63] != sbx)) ? 64'hFFF8_0000_0000_0000 : a_r;
          done_nxt = 1'b1;
          state_nxt = S_IDLE;
        end else if (b_inf) begin
          res_nxt = {sbx, 11'h7FF, 52'd0};
          done_nxt = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          sign_nxt  = a_big ? a_r[63] : sbx;
          esub_nxt  = a_r[63] ^ sbx;
          e_nxt     = e_big;
          d_nxt     = e_big - e_small;
          ma_nxt    = {big[62:52] != 11'd0, big[51:0], 3'b000};
          mb_nxt    = {little[62:52] != 11'd0, little[51:0], 3'b000};
          state_nxt = S_ALIGN;
        end
      end
      S_ALIGN: begin
        if (d_r >= 12'd56) mb_nxt = {55'd0, |mb_r};
        else mb_nxt = {shifted[55:1], shifted[0] | (|(mb_r & mask))};
        state_nxt = S_ADD;
      end
      S_ADD: begin
        m_nxt = esub_r ? ({1'b0, ma_r} - {1'b0, mb_r}) : ({1'b0, ma_r} + {1'b0, mb_r});
        state_nxt = S_NORM;
      end
      S_NORM: begin
        if (m_r == 57'd0) begin
          res_nxt = {esub_r ? 1'b0 : sign_r, 63'd0};
          done_nxt = 1'b1;
          state_nxt = S_IDLE;
        end else if (m_r[56]) begin
          m_nxt = {1'b0, m_r[56:2], m_r[1] | m_r[0]};
          e_nxt = e_r + 12'd1;
          state_nxt = S_ROUND;
        end else if (m_r[55] || (e_r == 12'd1)) begin
          state_nxt = S_ROUND;
        end else if ((m_r[55:40] == 16'd0) && (e_r > 12'd16)) begin
          m_nxt = m_r << 16;
          e_nxt = e_r - 12'd16;
        end else if ((m_r[55:52] == 4'd0) && (e_r > 12'd4)) begin
          m_nxt = m_r << 4;
          e_nxt = e_r - 12'd4;
        end else begin
          m_nxt = m_r << 1;
          e_nxt = e_r - 12'd1;
        end
      end
      S_ROUND: begin
        if (e_r >= 12'd2047) res_nxt = {sign_r, 11'h7FF, 52'd0};
        else res_nxt = pack + 64'(up);
        done_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == S_IDLE) && req.start) begin
      a_r   <= req.a;
      b_r   <= req.b;
      sub_r <= req.sub;
    end
    sign_r <= sign_nxt;
    esub_r <= esub_nxt;
    e_r    <= e_nxt;
    d_r    <= d_nxt;
    ma_r   <= ma_nxt;
    mb_r   <= mb_nxt;
    m_r    <= m_nxt;
    res_r  <= res_nxt;
  end

  assign rsp.done   = done_r;
  assign rsp.result = res_r;

endmodule

@@ hw/rtl/kta_store.sv @@
// Single-port pixel store holding compensation and sum per entry.
`timescale 1ns / 1ps
module kta_store
  import kta_pkg::*;
#(
  parameter int DEPTH = MAX_WIDTH_DEF * MAX_HEIGHT_DEF,
  parameter int AW    = $clog2(MAX_WIDTH_DEF * MAX_HEIGHT_DEF)
)(
  input  logic               clk,
  input  logic               we,
  input  logic [AW-1:0]      addr,
  input  logic [ENTRY_W-1:0] wdata,
  output logic [ENTRY_W-1:0] rdata
);

  logic [ENTRY_W-1:0] mem [DEPTH];
  logic [ENTRY_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

@@ dv/testbench.sv @@
// Self-checking testbench of the Kahan tile accumulator: random and corner transfers.
`timescale 1ns / 1ps
module testbench;
  import kta_pkg::*;

  localparam int IMG_MAX = 256;
  localparam int LIMIT   = 3000000;

  typedef struct packed {
    logic        cmd;
    logic [8:0]  origin_x;
    logic [8:0]  origin_y;
    logic [7:0]  offset_x;
    logic [7:0]  offset_y;
    logic [63:0] value;
  } pixel_item_t;

  typedef struct packed {
    logic        outside;
    logic [63:0] sum;
  } pixel_sum_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [103:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic out_tuser;
  logic cfg_we = 1'b0;
  logic cfg_addr = CFG_IDX_WIDTH;
  logic [CFG_W-1:0] cfg_wdata = '0;

  pixel_item_t pending_items[$];
  pixel_sum_t  expected_sums[$];
  pixel_item_t shown_item;
  logic [63:0] pixel_sum[int];
  logic [63:0] pixel_comp[int];
  int unsigned img_width = 256;
  int unsigned img_height = 256;
  int fails = 0;
  int cycles = 0;
  bit in_taken = 1'b0;
  bit calm = 1'b0;
  bit hold_input = 1'b0;

  kahan_tile_accumulator i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic report(input string what);
    $display("mismatch at cycle %0d: %s", cycles, what);
    fails++;
  endtask

  function automatic pixel_sum_t accumulate_pixel(input pixel_item_t it);
    pixel_sum_t r;
    int px, py, w, h, idx;
    real v, s, c, y, t, nc;
    px = $signed(it.origin_x) + int'(it.offset_x);
    py = $signed(it.origin_y) + int'(it.offset_y);
    w = (img_width < IMG_MAX) ? img_width : IMG_MAX;
    h = (img_height < IMG_MAX) ? img_height : IMG_MAX;
    r = '0;
    if (px < 0 || py < 0 || px >= w || py >= h) begin
      r.outside = 1'b1;
      return r;
    end
    idx = py * IMG_MAX + px;
    if (!pixel_sum.exists(idx)) begin
      pixel_sum[idx] = '0;
      pixel_comp[idx] = '0;
    end
    if (it.cmd == CMD_ACCUM) begin
      v = $bitstoreal(it.value);
      s = $bitstoreal(pixel_sum[idx]);
      c = $bitstoreal(pixel_comp[idx]);
      y = v - c;
      t = s + y;
      nc = (t - s) - y;
      pixel_comp[idx] = $realtobits(nc);
      pixel_sum[idx] = $realtobits(t);
    end
    r.sum = pixel_sum[idx];
    return r;
  endfunction

  always @(posedge clk) begin
    pixel_sum_t want;
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end else begin
      in_taken <= in_tvalid && in_tready;
      if (in_tvalid && in_tready)
        expected_sums.push_back(accumulate_pixel(shown_item));
      if (out_tvalid && out_tready) begin
        if (expected_sums.size() == 0) begin
          report("result with nothing expected");
        end else begin
          want = expected_sums.pop_front();
          if (out_tuser !== want.outside)
            report($sformatf("outside %b, want %b", out_tuser, want.outside));
          if (out_tdata !== want.sum)
            report($sformatf("sum %h, want %h", out_tdata, want.sum));
        end
      end
    end
  end

  always @(negedge clk) begin
    pixel_item_t it;
    out_tready <= calm || ($urandom_range(99) >= 9);
    if (rst_n && (!in_tvalid || in_taken)) begin
      if (pending_items.size() != 0 && !hold_input && (calm || $urandom_range(99) >= 9)) begin
        it = pending_items.pop_front();
        shown_item <= it;
        in_tvalid <= 1'b1;
        in_tuser <= it.cmd;
        in_tdata <= {6'd0, it.value, it.offset_y, it.offset_x, it.origin_y, it.origin_x};
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  task automatic add_item(input logic cmd, input int ox, input int oy, input int offx,
                          input int offy, input logic [63:0] val);
    pixel_item_t it;
    it.cmd = cmd;
    it.origin_x = ox[8:0];
    it.origin_y = oy[8:0];
    it.offset_x = offx[7:0];
    it.offset_y = offy[7:0];
    it.value = val;
    pending_items.push_back(it);
  endtask

  function automatic logic [63:0] random_double();
    logic [63:0] d;
    int pick;
    pick = $urandom_range(99);
    d = {$urandom, $urandom};
    if (pick < 85) d[62:52] = 11'd1023 + 11'($urandom_range(40)) - 11'd20;
    else if (pick < 88) d[62:52] = 11'h7FF;
    else if (pick < 91) d[62:52] = 11'h000;
    else if (pick < 93) d[51:0] = '0;
    return d;
  endfunction

  task automatic add_random(input int n);
    int px, py, offx, offy, lo, hi;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(99) < 15) begin
        add_item(1'($urandom_range(1)), $urandom_range(511), $urandom_range(511),
                 $urandom_range(255), $urandom_range(255), {$urandom, $urandom});
      end else begin
        px = ($urandom_range(1) ? $urandom_range(3) : $urandom_range(255));
        py = ($urandom_range(1) ? $urandom_range(3) : $urandom_range(255));
        lo = (px > 255) ? px - 255 : 0;
        hi = (px + 256 < 255) ? px + 256 : 255;
        offx = $urandom_range(hi, lo);
        lo = (py > 255) ? py - 255 : 0;
        hi = (py + 256 < 255) ? py + 256 : 255;
        offy = $urandom_range(hi, lo);
        add_item(($urandom_range(99) < 25) ? CMD_READ : CMD_ACCUM,
                 px - offx, py - offy, offx, offy, random_double());
      end
    end
  endtask

  task automatic drain();
    while (pending_items.size() != 0 || in_tvalid || expected_sums.size() != 0)
      @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_cfg(input logic idx, input int val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val[CFG_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_IDX_WIDTH) img_width = val[CFG_W-1:0];
    else img_height = val[CFG_W-1:0];
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    add_item(CMD_ACCUM, 0, 0, 0, 0, 64'h3FF0000000000000);
    add_item(CMD_ACCUM, 0, 0, 0, 0, 64'h3C90000000000000);
    add_item(CMD_ACCUM, 0, 0, 0, 0, 64'hBFF0000000000000);
    add_item(CMD_READ, 0, 0, 0, 0, 64'hFFFFFFFFFFFFFFFF);
    add_item(CMD_ACCUM, -256, -256, 255, 255, 64'h3FF0000000000000);
    add_item(CMD_ACCUM, 255, 255, 255, 255, 64'h3FF0000000000000);
    add_item(CMD_ACCUM, 255, 255, 0, 0, 64'h7FF0000000000000);
    add_item(CMD_ACCUM, 0, 255, 255, 0, 64'h0000000000000001);
    add_item(CMD_ACCUM, 0, 255, 255, 0, 64'h800FFFFFFFFFFFFF);
    add_item(CMD_ACCUM, -1, 3, 2, 0, 64'h7FF8000000000000);
    add_item(CMD_ACCUM, -1, 3, 2, 0, 64'h8000000000000000);
    add_item(CMD_READ, 1, 3, 0, 0, 64'd0);
    add_item(CMD_ACCUM, 5, -6, 0, 5, 64'h4000000000000000);
    add_item(CMD_READ, 255, 0, 0, 0, 64'd0);
    add_random(150);
    drain();
    write_cfg(CFG_IDX_WIDTH, 511);
    write_cfg(CFG_IDX_HEIGHT, 300);
    add_random(150);
    hold_input = 1'b0;
    while (pending_items.size() > 100) @(posedge clk);
    hold_input = 1'b1;
    while (in_tvalid || expected_sums.size() != 0) @(posedge clk);
    hold_input = 1'b0;
    drain();
    write_cfg(CFG_IDX_WIDTH, 0);
    write_cfg(CFG_IDX_HEIGHT, 5);
    add_random(40);
    drain();
    write_cfg(CFG_IDX_WIDTH, 1);
    write_cfg(CFG_IDX_HEIGHT, 1);
    add_item(CMD_ACCUM, 0, 0, 0, 0, 64'h3FF0000000000000);
    add_item(CMD_ACCUM, 0, 0, 1, 0, 64'h3FF0000000000000);
    add_item(CMD_ACCUM, 0, 0, 0, 1, 64'h3FF0000000000000);
    add_random(60);
    drain();
    write_cfg(CFG_IDX_WIDTH, 17);
    write_cfg(CFG_IDX_HEIGHT, 200);
    calm = 1'b1;
    add_random(250);
    drain();
    calm = 1'b0;
    write_cfg(CFG_IDX_WIDTH, 256);
    write_cfg(CFG_IDX_HEIGHT, 256);
    add_random(350);
    drain();
    if (fails == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/kta_pkg.sv
hw/rtl/kta_fp_add.sv
hw/rtl/kta_store.sv
hw/rtl/kahan_tile_accumulator.sv
dv/testbench.sv
